[src/sfla_pkg.sv]
// Package with command codes, status codes, the granule size and item types of the allocator.
package sfla_pkg;

  localparam logic [1:0] CMD_INIT  = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_ALLOC = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_LOST    = 2'd1;
  localparam logic [1:0] ST_NOSPACE = 2'd2;

  // Sizes are rounded to this many bytes. It is a power of two, so rounding is a mask.
  localparam int GRANULE_BYTES = 16;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] region_addr;
    logic [31:0] region_size;
  } in_item_t;

  typedef struct packed {
    logic [31:0] alloc_addr;
    logic [1:0]  status;
    logic [10:0] entries_in_use;
    logic [10:0] peak_entries;
    logic [31:0] lost_count;
    logic [31:0] lost_bytes;
  } out_item_t;

endpackage

[src/sorted_free_list_allocator.sv]
// Top level of the sorted free list allocator with first-fit allocation and coalescing.
//
// Usage: one command item enters on in_valid/in_ready (init, free or allocate) and
// exactly one result item leaves on out_valid/out_ready. The table of free regions
// lives in one synchronous memory with a registered read port; each word holds a
// region start and length. The sequencer scans the table entry by entry
// (read, then check) to find the insertion point or the first fitting region, then
// shifts entries up or down entry by entry (read, then write). One command is worked
// on at a time, and the next is taken only once the block is back in idle.
// The result sits in an output register; the next command is accepted while it
// waits, and its result is held back until the receiver takes the previous one.
// At reset the entry count, peak and lost counters clear; the memory is not
// cleared, since only entries below the count are ever read. A stalled receiver
// only delays the block.
module sorted_free_list_allocator #(
  parameter int TABLE_ENTRIES = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sfla_pkg::in_item_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output sfla_pkg::out_item_t out_data
);
  import sfla_pkg::*;

  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] CAP = CW'(TABLE_ENTRIES);
  localparam logic [31:0] GM1 = 32'(GRANULE_BYTES - 1);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_SCAN  = 10'b0000000010,
    S_CHK   = 10'b0000000100,
    S_DECIDE= 10'b0000001000,
    S_UPRD  = 10'b0000010000,
    S_UPWR  = 10'b0000100000,
    S_DNRD  = 10'b0001000000,
    S_DNWR  = 10'b0010000000,
    S_DONE  = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_t;

  state_t state_r;
  logic [1:0]  cmd_r;
  logic [31:0] addr_r, size_r;
  logic [CW-1:0] cnt_r, peak_r, idx_r, pos_r;
  logic [31:0] lost_n_r, lost_b_r;
  logic [31:0] res_addr_r;
  logic [1:0]  res_st_r;
  logic        rd_v_r;
  logic [31:0] prev_s_r, prev_l_r, cur_s_r, cur_l_r;
  logic        have_prev_r;
  logic        out_valid_r;
  out_item_t   out_r;

  // Single-entry writes from the decide and shift-up states are posted here.
  logic          pw_r;
  logic [AW-1:0] pw_a_r;
  logic [63:0]   pw_d_r;

  // Table memory: start in high half, length in low half.
  logic [63:0] mem [TABLE_ENTRIES];
  logic [63:0] rdata_r;
  logic        we;
  logic [AW-1:0] waddr, raddr;
  logic [63:0] wdata;
  logic        re;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_r <= mem[raddr];
  end

  wire [31:0] rd_s = rdata_r[63:32];
  wire [31:0] rd_l = rdata_r[31:0];

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data = out_r;

  // Rounded sizes.
  logic [31:0] rnd_dn, rnd_up;
  always_comb begin
    rnd_dn = in_data.region_size & ~GM1;
    rnd_up = (in_data.region_size + GM1) & ~GM1;
  end

  wire [31:0] in_end  = addr_r + size_r;
  wire [31:0] prv_end = prev_s_r + prev_l_r;

  // Memory port control. A posted write never falls in a shift-write cycle.
  always_comb begin
    re = 1'b0; raddr = '0; we = 1'b0; waddr = '0; wdata = '0;
    case (state_r)
      S_SCAN: begin
        re = (idx_r < cnt_r);
        raddr = idx_r[AW-1:0];
      end
      S_UPRD: begin
        re = 1'b1;
        raddr = AW'(idx_r - CW'(1));
      end
      S_UPWR: begin
        we = 1'b1;
        waddr = idx_r[AW-1:0];
        wdata = rdata_r;
      end
      S_DNRD: begin
        re = 1'b1;
        raddr = AW'(idx_r + CW'(1));
      end
      S_DNWR: begin
        we = 1'b1;
        waddr = idx_r[AW-1:0];
        wdata = rdata_r;
      end
      default: ;
    endcase
    if (pw_r) begin
      we = 1'b1;
      waddr = pw_a_r;
      wdata = pw_d_r;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0; peak_r <= '0; lost_n_r <= '0; lost_b_r <= '0;
      out_valid_r <= 1'b0; rd_v_r <= 1'b0;
      pw_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && state_r != S_OUT) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            cmd_r <= in_data.command;
            addr_r <= in_data.region_addr;
            idx_r <= '0;
            rd_v_r <= 1'b0;
            have_prev_r <= 1'b0;
            res_addr_r <= '0;
            res_st_r <= ST_OK;
            case (in_data.command)
              CMD_INIT: begin
                size_r <= rnd_dn;
                cnt_r <= '0; peak_r <= '0; lost_n_r <= '0; lost_b_r <= '0;
                state_r <= S_DECIDE;
              end
              CMD_FREE: begin
                size_r <= rnd_up;
                state_r <= S_SCAN;
              end
              CMD_ALLOC: begin
                size_r <= rnd_up;
                state_r <= S_SCAN;
              end
              default: state_r <= S_DONE;
            endcase
          end
        end
        // One read issued per entry; S_CHK looks at the returned word.
        S_SCAN: begin
          if (idx_r < cnt_r) begin
            state_r <= S_CHK;
          end else begin
            pos_r <= idx_r;
            state_r <= S_DECIDE;
          end
        end
        S_CHK: begin
          if (cmd_r == CMD_ALLOC) begin
            if (rd_l >= size_r) begin
              pos_r <= idx_r;
              cur_s_r <= rd_s; cur_l_r <= rd_l;
              rd_v_r <= 1'b1;
              state_r <= S_DECIDE;
            end else begin
              idx_r <= idx_r + CW'(1);
              state_r <= S_SCAN;
            end
          end else if (rd_s > addr_r) begin
            pos_r <= idx_r;
            cur_s_r <= rd_s; cur_l_r <= rd_l;
            rd_v_r <= 1'b1;
            state_r <= S_DECIDE;
          end else begin
            prev_s_r <= rd_s; prev_l_r <= rd_l;
            have_prev_r <= 1'b1;
            idx_r <= idx_r + CW'(1);
            state_r <= S_SCAN;
          end
        end
        S_DECIDE: begin
          if (cmd_r == CMD_ALLOC) begin
            if (!rd_v_r) begin
              res_st_r <= ST_NOSPACE;
              state_r <= S_DONE;
            end else begin
              res_addr_r <= cur_s_r;
              if (cur_l_r == size_r) begin
                cnt_r <= cnt_r - CW'(1);
                idx_r <= pos_r;
                state_r <= (pos_r + CW'(1) < cnt_r) ? S_DNRD : S_DONE;
              end else begin
                pw_r <= 1'b1;
                pw_a_r <= pos_r[AW-1:0];
                pw_d_r <= {cur_s_r + size_r, cur_l_r - size_r};
                state_r <= S_DONE;
              end
            end
          end else if (cmd_r == CMD_INIT) begin
            pw_r <= 1'b1;
            pw_a_r <= '0;
            pw_d_r <= {addr_r, size_r};
            cnt_r <= CW'(1);
            peak_r <= CW'(1);
            state_r <= S_DONE;
          end else if (have_prev_r && prv_end == addr_r) begin
            pw_r <= 1'b1;
            pw_a_r <= AW'(pos_r - CW'(1));
            if (rd_v_r && in_end == cur_s_r) begin
              pw_d_r <= {prev_s_r, prev_l_r + size_r + cur_l_r};
              cnt_r <= cnt_r - CW'(1);
              idx_r <= pos_r;
              state_r <= (pos_r + CW'(1) < cnt_r) ? S_DNRD : S_DONE;
            end else begin
              pw_d_r <= {prev_s_r, prev_l_r + size_r};
              state_r <= S_DONE;
            end
          end else if (rd_v_r && in_end == cur_s_r) begin
            pw_r <= 1'b1;
            pw_a_r <= pos_r[AW-1:0];
            pw_d_r <= {addr_r, cur_l_r + size_r};
            state_r <= S_DONE;
          end else if (cnt_r < CAP) begin
            idx_r <= cnt_r;
            state_r <= (cnt_r > pos_r) ? S_UPRD : S_DONE;
            if (cnt_r == pos_r) begin
              pw_r <= 1'b1;
              pw_a_r <= pos_r[AW-1:0];
              pw_d_r <= {addr_r, size_r};
            end
            cnt_r <= cnt_r + CW'(1);
            if (peak_r < cnt_r + CW'(1)) peak_r <= cnt_r + CW'(1);
          end else begin
            res_st_r <= ST_LOST;
            if (lost_n_r != 32'hffffffff) lost_n_r <= lost_n_r + 32'd1;
            lost_b_r <= (lost_b_r > (32'hffffffff - size_r)) ? 32'hffffffff
                                                             : lost_b_r + size_r;
            state_r <= S_DONE;
          end
        end
        // Shift up: entry idx-1 moves to idx.
        S_UPRD: state_r <= S_UPWR;
        S_UPWR: begin
          if (idx_r - CW'(1) == pos_r) begin
            pw_r <= 1'b1;
            pw_a_r <= pos_r[AW-1:0];
            pw_d_r <= {addr_r, size_r};
            state_r <= S_DONE;
          end else begin
            idx_r <= idx_r - CW'(1);
            state_r <= S_UPRD;
          end
        end
        // Shift down: entry idx+1 moves to idx; cnt already decremented.
        S_DNRD: begin
          pw_r <= 1'b0;
          state_r <= S_DNWR;
        end
        S_DNWR: begin
          idx_r <= idx_r + CW'(1);
          state_r <= (idx_r + CW'(2) <= cnt_r) ? S_DNRD : S_DONE;
        end
        S_DONE: begin
          pw_r <= 1'b0;
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_r.alloc_addr <= res_addr_r;
            out_r.status <= res_st_r;
            out_r.entries_in_use <= 11'(cnt_r);
            out_r.peak_entries <= 11'(peak_r);
            out_r.lost_count <= lost_n_r;
            out_r.lost_bytes <= lost_b_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Assertions.
  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= CAP)
    else $error("entry count above capacity");
  a_peak: assert property (@(posedge clk) disable iff (!rst_n) peak_r >= cnt_r)
    else $error("peak below entry count");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

endmodule
